FILE: rtl/assert_macros.svh
// Assertion macros shared by the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during rst.
`define CHK_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication, sampled on clk, off during rst.
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`else
`define CHK_SAME(lbl, ante, cons)
`define CHK_NEXT(lbl, ante, cons)
`endif
`endif

FILE: rtl/cset_pkg.sv
// Shared constants and types for the CAN sensor event tracker.
`timescale 1ns / 1ps
package cset_pkg;
  localparam int SENSOR_COUNT = 80;
  localparam int IDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int OUT_IDX_W = 7;
  localparam int NUM_W = 16;
  localparam int CNT_W = 32;
  localparam int STAMP_W = 16;

  localparam logic [7:0] CMD_CODE = 8'h11;
  localparam int CMD_LSB = 17;
  localparam int RESP_BIT = 16;
  localparam logic [3:0] FRAME_LEN = 4'd8;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_REJECT   = 2'd0,
    ST_DUP      = 2'd1,
    ST_APPLIED  = 2'd2,
    ST_OCCUPIED = 2'd3
  } status_t;

  // Decoded report passed from front to back.
  typedef struct packed {
    logic               ok;
    logic [IDX_W-1:0]   idx;
    logic               old_bit;
    logic               new_bit;
    logic [STAMP_W-1:0] stamp;
  } report_t;

  // Queue handshake toward the back end.
  typedef struct packed {
    logic    valid;
    report_t head;
  } queue_head_t;
endpackage

FILE: rtl/cset_frame_if.sv
// Input channel: one received CAN frame per word.
`timescale 1ns / 1ps
interface cset_frame_if;
  logic        valid;
  logic        ready;
  logic        frame_is_extended;
  logic [3:0]  frame_length;
  logic [28:0] frame_id;
  logic [7:0]  payload_byte2;
  logic [7:0]  payload_byte3;
  logic [7:0]  payload_byte4;
  logic [7:0]  payload_byte5;
  logic [7:0]  payload_byte6;
  logic [7:0]  payload_byte7;

  modport source (output valid, frame_is_extended, frame_length, frame_id, payload_byte2,
                  payload_byte3, payload_byte4, payload_byte5, payload_byte6, payload_byte7,
                  input ready);
  modport sink (input valid, frame_is_extended, frame_length, frame_id, payload_byte2,
                payload_byte3, payload_byte4, payload_byte5, payload_byte6, payload_byte7,
                output ready);
endinterface

FILE: rtl/cset_result_if.sv
// Output channel: one tracker result per word.
`timescale 1ns / 1ps
interface cset_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [6:0]  sensor_slot;
  logic        stored_state;
  logic [15:0] timestamp;
  logic        inconsistent;
  logic        resynchronized;
  logic [31:0] event_total;
  logic [31:0] occupation_total;
  logic [31:0] mismatch_total;
  logic [31:0] duplicate_total;
  logic [31:0] resync_total;

  modport source (output valid, status, sensor_slot, stored_state, timestamp, inconsistent,
                  resynchronized, event_total, occupation_total, mismatch_total,
                  duplicate_total, resync_total, input ready);
  modport sink (input valid, status, sensor_slot, stored_state, timestamp, inconsistent,
                resynchronized, event_total, occupation_total, mismatch_total,
                duplicate_total, resync_total, output ready);
endinterface

FILE: rtl/cset_front.sv
// Front end: frame acceptance and decode into a report word.
`timescale 1ns / 1ps
module cset_front import cset_pkg::*; (
  cset_frame_if.sink frame,
  input  logic       queue_full,
  output logic       push,
  output report_t    report
);
  logic [NUM_W-1:0] number;
  logic [NUM_W-1:0] number_m1;
  logic             ok;

  assign frame.ready = !queue_full;
  assign push        = frame.valid && !queue_full;

  assign number    = {frame.payload_byte2, frame.payload_byte3};
  assign number_m1 = number - NUM_W'(1);

  always_comb begin
    ok = frame.frame_is_extended
      && (frame.frame_length == FRAME_LEN)
      && (frame.frame_id[CMD_LSB +: 8] == CMD_CODE)
      && frame.frame_id[RESP_BIT]
      && (number != '0)
      && (number <= NUM_W'(SENSOR_COUNT))
      && (frame.payload_byte4[7:1] == '0)
      && (frame.payload_byte5[7:1] == '0);
    report.ok      = ok;
    // rejected frames carry zero payload so the back end can pass it straight out
    report.idx     = ok ? number_m1[IDX_W-1:0] : '0;
    report.old_bit = ok & frame.payload_byte4[0];
    report.new_bit = ok & frame.payload_byte5[0];
    report.stamp   = ok ? {frame.payload_byte6, frame.payload_byte7} : '0;
  end
endmodule

FILE: rtl/cset_queue.sv
// Short FIFO of decoded reports between front and back.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cset_queue import cset_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  report_t     push_data,
  output logic        full,
  input  logic        pop,
  output queue_head_t head
);
  report_t             mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.head  = mem[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head.valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  `CHK_SAME(a_count_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH))
  `CHK_NEXT(a_push_fills, do_push && !do_pop, count == $past(count) + QCNT_W'(1))
  `CHK_NEXT(a_pop_drains, do_pop && !do_push, count == $past(count) - QCNT_W'(1))
endmodule

FILE: rtl/cset_back.sv
// Back end: occupancy update, counters and the output register.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module cset_back import cset_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  cset_result_if.source result
);
  logic [SENSOR_COUNT-1:0] occ;
  logic [SENSOR_COUNT-1:0] occ_next;
  logic [CNT_W-1:0]        applied_cnt;
  logic [CNT_W-1:0]        occup_cnt;
  logic [CNT_W-1:0]        mismatch_cnt;
  logic [CNT_W-1:0]        dup_cnt;
  logic [CNT_W-1:0]        resync_cnt;
  logic                    out_valid;

  report_t                 r;
  logic                    prev;
  logic                    dup;
  logic                    apply;
  logic                    rise;
  logic                    resync;
  logic                    incons;
  status_t                 status_next;
  logic [NUM_W-1:0]        idx_wide;

  assign r        = head.head;
  assign pop      = head.valid && (!out_valid || result.ready);
  assign prev     = occ[r.idx];
  assign dup      = r.ok && prev && r.old_bit && r.new_bit;
  assign apply    = r.ok && !dup;
  assign rise     = apply && r.new_bit;
  assign resync   = apply && prev && !r.old_bit && r.new_bit;
  assign incons   = apply && (prev != r.old_bit);
  assign idx_wide = NUM_W'(r.idx);

  always_comb begin
    occ_next = occ;
    if (apply) begin
      occ_next[r.idx] = r.new_bit;
    end
    if (!r.ok) begin
      status_next = ST_REJECT;
    end else if (dup) begin
      status_next = ST_DUP;
    end else if (rise) begin
      status_next = ST_OCCUPIED;
    end else begin
      status_next = ST_APPLIED;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ          <= '0;
      applied_cnt  <= '0;
      occup_cnt    <= '0;
      mismatch_cnt <= '0;
      dup_cnt      <= '0;
      resync_cnt   <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        occ          <= occ_next;
        applied_cnt  <= applied_cnt + CNT_W'(apply);
        occup_cnt    <= occup_cnt + CNT_W'(rise);
        mismatch_cnt <= mismatch_cnt + CNT_W'(incons);
        dup_cnt      <= dup_cnt + CNT_W'(dup);
        resync_cnt   <= resync_cnt + CNT_W'(resync);
        out_valid    <= 1'b1;
      end else if (result.ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  // result payload; totals show the counters after this word
  always_ff @(posedge clk) begin
    if (pop) begin
      result.status           <= status_next;
      result.sensor_slot      <= idx_wide[OUT_IDX_W-1:0];
      result.stored_state     <= dup | (apply & r.new_bit);
      result.timestamp        <= r.stamp;
      result.inconsistent     <= incons;
      result.resynchronized   <= resync;
      result.event_total      <= applied_cnt + CNT_W'(apply);
      result.occupation_total <= occup_cnt + CNT_W'(rise);
      result.mismatch_total   <= mismatch_cnt + CNT_W'(incons);
      result.duplicate_total  <= dup_cnt + CNT_W'(dup);
      result.resync_total     <= resync_cnt + CNT_W'(resync);
    end
  end

  assign result.valid = out_valid;

  `CHK_NEXT(a_reject_keeps_occ, pop && !r.ok, occ == $past(occ))
  `CHK_NEXT(a_pop_shows_word, pop, out_valid)
  `CHK_SAME(a_total_matches_cnt, out_valid, result.event_total == applied_cnt)
  `CHK_SAME(a_dup_is_high, out_valid && (result.status == ST_DUP), result.stored_state)
endmodule

FILE: rtl/can_sensor_event_tracker.sv
// Top level of the CAN sensor event tracker.
`timescale 1ns / 1ps
//
//   channel  dir  modport  word
//   -------  ---  -------  ------------------------------------------------
//   frame    in   sink     one received CAN frame (flags, id, bytes 2..7)
//   result   out  source   status, sensor index, state, stamp, flags, five totals
//
// A word is taken on frame at any edge where the two-entry queue has room,
// one per cycle sustained while result.ready stays high; each produces
// exactly one result word. Decode is combinational into the queue, which
// registers the report; the update stage then registers the result.
// The back end's per-cycle read-modify-write of the occupancy bit and the
// counters sets the 1-word-per-cycle rate while result.ready stays high.
// rst (synchronous, active high) clears occupancy, all totals and the queue.
// A stalled result holds in its register; the queue absorbs two more frames
// before frame.ready drops.
module can_sensor_event_tracker import cset_pkg::*; (
  input  logic           clk,
  input  logic           rst,
  cset_frame_if.sink     frame,
  cset_result_if.source  result
);
  logic        push;
  logic        full;
  logic        pop;
  report_t     report;
  queue_head_t head;

  // decode and accept
  cset_front u_front (
    .frame      (frame),
    .queue_full (full),
    .push       (push),
    .report     (report)
  );

  // decoupling queue
  cset_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (report),
    .full      (full),
    .pop       (pop),
    .head      (head)
  );

  // state update and result register
  cset_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (head),
    .pop    (pop),
    .result (result)
  );
endmodule

FILE: tb/sensor_report_checker.sv
// Checker for the sensor event tracker: predicts each result word and compares it.
`timescale 1ns / 1ps
module sensor_report_checker import cset_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  cset_frame_if   frame,
  cset_result_if  result,
  output int      outstanding,
  output int      fail_count
);

  typedef struct {
    status_t     status;
    logic [6:0]  sensor_slot;
    logic        stored_state;
    logic [15:0] timestamp;
    logic        inconsistent;
    logic        resynchronized;
    logic [31:0] event_total;
    logic [31:0] occupation_total;
    logic [31:0] mismatch_total;
    logic [31:0] duplicate_total;
    logic [31:0] resync_total;
  } tracker_word_t;

  logic        sensor_occupied [SENSOR_COUNT];
  logic [31:0] applied_cnt;
  logic [31:0] occupation_cnt;
  logic [31:0] mismatch_cnt;
  logic [31:0] duplicate_cnt;
  logic [31:0] resync_cnt;

  tracker_word_t expected_reports [$];

  // Updates the tracked occupancy and totals for one frame and returns its result word.
  function automatic tracker_word_t predict_report(
    input logic        ext,
    input logic [3:0]  dlc,
    input logic [28:0] id,
    input logic [7:0]  num_hi,
    input logic [7:0]  num_lo,
    input logic [7:0]  old_s,
    input logic [7:0]  new_s,
    input logic [7:0]  stamp_hi,
    input logic [7:0]  stamp_lo
  );
    tracker_word_t w;
    logic [15:0]   number;
    int            idx;
    logic          prev;
    logic          rise;
    logic          accept;
    number = {num_hi, num_lo};
    accept = ext && dlc == FRAME_LEN && id[CMD_LSB +: 8] == CMD_CODE && id[RESP_BIT] &&
             number >= 1 && number <= SENSOR_COUNT && old_s <= 8'd1 && new_s <= 8'd1;
    w.status         = ST_REJECT;
    w.sensor_slot    = '0;
    w.stored_state   = 1'b0;
    w.timestamp      = '0;
    w.inconsistent   = 1'b0;
    w.resynchronized = 1'b0;
    if (accept) begin
      idx            = int'(number) - 1;
      w.sensor_slot  = idx[6:0];
      w.timestamp    = {stamp_hi, stamp_lo};
      prev           = sensor_occupied[idx];
      if (prev && old_s[0] && new_s[0]) begin
        duplicate_cnt  = duplicate_cnt + 1;
        w.status       = ST_DUP;
        w.stored_state = 1'b1;
      end else begin
        rise = !prev && new_s[0];
        // 0->1 report on a sensor already high: resync, still a new occupation
        if (!rise && prev && !old_s[0] && new_s[0]) begin
          rise             = 1'b1;
          w.resynchronized = 1'b1;
          resync_cnt       = resync_cnt + 1;
        end
        if (prev != old_s[0]) begin
          w.inconsistent = 1'b1;
          mismatch_cnt   = mismatch_cnt + 1;
        end
        sensor_occupied[idx] = new_s[0];
        w.stored_state       = new_s[0];
        applied_cnt          = applied_cnt + 1;
        if (rise) begin
          occupation_cnt = occupation_cnt + 1;
          w.status       = ST_OCCUPIED;
        end else begin
          w.status = ST_APPLIED;
        end
      end
    end
    w.event_total      = applied_cnt;
    w.occupation_total = occupation_cnt;
    w.mismatch_total   = mismatch_cnt;
    w.duplicate_total  = duplicate_cnt;
    w.resync_total     = resync_cnt;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    tracker_word_t want;
    if (rst) begin
      foreach (sensor_occupied[i]) sensor_occupied[i] = 1'b0;
      applied_cnt    = '0;
      occupation_cnt = '0;
      mismatch_cnt   = '0;
      duplicate_cnt  = '0;
      resync_cnt     = '0;
      expected_reports.delete();
      fail_count = 0;
    end else begin
      if (frame.valid && frame.ready) begin
        expected_reports.push_back(predict_report(frame.frame_is_extended, frame.frame_length,
            frame.frame_id, frame.payload_byte2, frame.payload_byte3, frame.payload_byte4,
            frame.payload_byte5, frame.payload_byte6, frame.payload_byte7));
      end
      if (result.valid && result.ready) begin
        if (expected_reports.size() == 0) begin
          $error("result word arrived with no frame pending");
          fail_count++;
        end else begin
          want = expected_reports.pop_front();
          check_field("status", 32'(want.status), 32'(result.status));
          check_field("sensor_slot", 32'(want.sensor_slot), 32'(result.sensor_slot));
          check_field("stored_state", 32'(want.stored_state), 32'(result.stored_state));
          check_field("timestamp", 32'(want.timestamp), 32'(result.timestamp));
          check_field("inconsistent", 32'(want.inconsistent), 32'(result.inconsistent));
          check_field("resynchronized", 32'(want.resynchronized),
                      32'(result.resynchronized));
          check_field("event_total", want.event_total, result.event_total);
          check_field("occupation_total", want.occupation_total, result.occupation_total);
          check_field("mismatch_total", want.mismatch_total, result.mismatch_total);
          check_field("duplicate_total", want.duplicate_total, result.duplicate_total);
          check_field("resync_total", want.resync_total, result.resync_total);
        end
      end
    end
    outstanding <= expected_reports.size();
  end

endmodule

FILE: tb/tb_can_sensor_event_tracker.sv
// Testbench top for the CAN sensor event tracker: clock, reset, frame stimulus and verdict.
`timescale 1ns / 1ps
module tb_can_sensor_event_tracker;
  import cset_pkg::*;

  // Watchdog limit for a run of 1552 words, each with a random sender gap
  // and a random result stall.
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 1530;
  localparam int DRAIN_AT = 700;       // full drain of the tracker partway through
  localparam int STEADY_FIRST = 900;   // stall-free stretch on both sides
  localparam int STEADY_LAST = 1100;

  // One received CAN frame, as carried by one word on the frame channel.
  typedef struct {
    logic        extended;
    logic [3:0]  dlc;
    logic [28:0] id;
    logic [7:0]  sensor_hi;
    logic [7:0]  sensor_lo;
    logic [7:0]  prior_state;
    logic [7:0]  report_state;
    logic [7:0]  stamp_hi;
    logic [7:0]  stamp_lo;
  } sensor_frame_t;

  logic clk = 1'b0;
  logic rst;
  logic steady_run;
  int   outstanding;
  int   fail_count;
  int   cycle_count;
  int   directed_sent;
  int   reports_sent;
  int   noise_sent;

  cset_frame_if  frame_ch ();
  cset_result_if result_ch ();

  can_sensor_event_tracker DUT (
    .clk    (clk),
    .rst    (rst),
    .frame  (frame_ch),
    .result (result_ch)
  );

  sensor_report_checker checker_inst (
    .clk         (clk),
    .rst         (rst),
    .frame       (frame_ch),
    .result      (result_ch),
    .outstanding (outstanding),
    .fail_count  (fail_count)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Result side backpressure: ready drops at random with a chance of 29 in 100,
  // and is held high through the steady stretch.
  always @(posedge clk) begin
    result_ch.ready <= steady_run || ($urandom_range(0, 99) >= 29);
  end

  // Well-formed sensor report; id bits outside command and response flag are random.
  function automatic sensor_frame_t sensor_report(input int unsigned sensor,
                                                  input logic [7:0] old_s,
                                                  input logic [7:0] new_s,
                                                  input logic [15:0] stamp);
    sensor_frame_t f;
    f.extended            = 1'b1;
    f.dlc                 = FRAME_LEN;
    f.id                  = 29'($urandom);
    f.id[CMD_LSB +: 8]    = CMD_CODE;
    f.id[RESP_BIT]        = 1'b1;
    {f.sensor_hi, f.sensor_lo} = sensor[15:0];
    f.prior_state         = old_s;
    f.report_state        = new_s;
    {f.stamp_hi, f.stamp_lo}   = stamp;
    return f;
  endfunction

  // Offers one word on the frame channel and returns at the edge that takes it.
  // Outside the steady stretch the sender idles at random before offering.
  task automatic push_frame(input sensor_frame_t f);
    if (!steady_run) begin
      while ($urandom_range(0, 99) < 29) begin
        frame_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    frame_ch.valid             <= 1'b1;
    frame_ch.frame_is_extended <= f.extended;
    frame_ch.frame_length      <= f.dlc;
    frame_ch.frame_id          <= f.id;
    frame_ch.payload_byte2     <= f.sensor_hi;
    frame_ch.payload_byte3     <= f.sensor_lo;
    frame_ch.payload_byte4     <= f.prior_state;
    frame_ch.payload_byte5     <= f.report_state;
    frame_ch.payload_byte6     <= f.stamp_hi;
    frame_ch.payload_byte7     <= f.stamp_lo;
    do @(posedge clk); while (!frame_ch.ready);
  endtask

  // Stops sending and waits until every pending result word has come back.
  // The count from the checker is a registered copy, so the loop waits on the clock before it first tests it.
  task automatic drain_results();
    frame_ch.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  // Run watchdog.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    sensor_frame_t directed [$];
    sensor_frame_t f;
    int unsigned   kind;
    int unsigned   sensor;
    logic [7:0]    code;
    logic [3:0]    len;

    rst                        = 1'b1;
    steady_run                 = 1'b0;
    frame_ch.valid             = 1'b0;
    frame_ch.frame_is_extended = 1'b0;
    frame_ch.frame_length      = '0;
    frame_ch.frame_id          = '0;
    frame_ch.payload_byte2     = '0;
    frame_ch.payload_byte3     = '0;
    frame_ch.payload_byte4     = '0;
    frame_ch.payload_byte5     = '0;
    frame_ch.payload_byte6     = '0;
    frame_ch.payload_byte7     = '0;
    directed_sent              = 0;
    reports_sent               = 0;
    noise_sent                 = 0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // ---- directed: every reject reason, then each state transition ----
    f = sensor_report(1, 0, 1, 16'hFFFF); f.extended = 1'b0;         directed.push_back(f);
    f = sensor_report(1, 0, 1, 16'h1234); f.dlc = 4'd7;              directed.push_back(f);
    f = sensor_report(1, 0, 1, 16'h1234); f.dlc = 4'd15;             directed.push_back(f);
    f = sensor_report(1, 0, 1, 16'h1234); f.dlc = 4'd0;              directed.push_back(f);
    f = sensor_report(1, 0, 1, 16'h1234); f.id[CMD_LSB +: 8] = 8'h10; directed.push_back(f);
    // all-ones id: command field reads 0xff
    f = sensor_report(1, 0, 1, 16'h1234); f.id = '1;                 directed.push_back(f);
    // response flag missing
    f = sensor_report(1, 0, 1, 16'h1234); f.id[RESP_BIT] = 1'b0;     directed.push_back(f);
    // sensor numbers out of range: zero, one past the top, all ones
    f = sensor_report(0, 0, 1, 16'h1234);                            directed.push_back(f);
    f = sensor_report(SENSOR_COUNT + 1, 0, 1, 16'h1234);             directed.push_back(f);
    f = sensor_report(16'hFFFF, 0, 1, 16'h1234);                     directed.push_back(f);
    // state bytes outside 0/1
    f = sensor_report(1, 8'd2, 1, 16'h1234);                         directed.push_back(f);
    f = sensor_report(1, 0, 8'hFF, 16'h1234);                        directed.push_back(f);
    // lowest sensor: rise, duplicate high, resync rise, fall, steady low
    directed.push_back(sensor_report(1, 0, 1, 16'hFFFF));
    directed.push_back(sensor_report(1, 1, 1, 16'h0001));
    directed.push_back(sensor_report(1, 0, 1, 16'h8000));
    directed.push_back(sensor_report(1, 1, 0, 16'h00FF));
    directed.push_back(sensor_report(1, 0, 0, 16'hFF00));
    // highest sensor: old state disagreeing with stored state
    directed.push_back(sensor_report(SENSOR_COUNT, 1, 0, 16'h0000));
    directed.push_back(sensor_report(SENSOR_COUNT, 1, 1, 16'h5A5A));
    directed.push_back(sensor_report(SENSOR_COUNT, 0, 0, 16'hA5A5));
    // accepted frame with every id bit set outside the command field
    f = sensor_report(SENSOR_COUNT, 0, 1, 16'h0000);
    f.id = '1; f.id[CMD_LSB +: 8] = CMD_CODE;                        directed.push_back(f);
    // accepted frame with only command and response bits set
    f = sensor_report(SENSOR_COUNT / 2, 0, 1, 16'h00FF);
    f.id = '0; f.id[CMD_LSB +: 8] = CMD_CODE; f.id[RESP_BIT] = 1'b1; directed.push_back(f);

    foreach (directed[i]) begin
      push_frame(directed[i]);
      directed_sent++;
    end

    // ---- random: mostly well-formed reports on a few hot sensors ----
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == DRAIN_AT) drain_results();
      if (n == STEADY_FIRST) steady_run <= 1'b1;
      if (n == STEADY_LAST) steady_run <= 1'b0;

      kind = $urandom_range(0, 99);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: sensor = $urandom_range(1, 6);
        9:             sensor = ($urandom_range(0, 1) != 0) ? SENSOR_COUNT : 1;
        default:       sensor = $urandom_range(1, SENSOR_COUNT);
      endcase
      f = sensor_report(sensor, 8'($urandom_range(0, 1)), 8'($urandom_range(0, 1)),
                        16'($urandom));

      if (kind < 12) begin
        // pure noise: every field at random
        f.extended     = 1'($urandom);
        f.dlc          = 4'($urandom);
        f.id           = 29'($urandom);
        f.sensor_hi    = 8'($urandom);
        f.sensor_lo    = 8'($urandom);
        f.prior_state  = 8'($urandom);
        f.report_state = 8'($urandom);
        f.stamp_hi     = 8'($urandom);
        f.stamp_lo     = 8'($urandom);
        noise_sent++;
      end else if (kind < 25) begin
        // report broken in exactly one way
        case ($urandom_range(0, 6))
          0: f.extended = 1'b0;
          1: begin
            len = 4'($urandom_range(0, 15));
            if (len == FRAME_LEN) len = 4'd9;
            f.dlc = len;
          end
          2: begin
            code = 8'($urandom_range(0, 255));
            if (code == CMD_CODE) code = code ^ 8'h01;
            f.id[CMD_LSB +: 8] = code;
          end
          3: f.id[RESP_BIT] = 1'b0;
          4: begin
            if ($urandom_range(0, 1) != 0) {f.sensor_hi, f.sensor_lo} = 16'd0;
            else {f.sensor_hi, f.sensor_lo} = 16'($urandom_range(SENSOR_COUNT + 1, 65535));
          end
          5: f.prior_state = 8'($urandom_range(2, 255));
          default: f.report_state = 8'($urandom_range(2, 255));
        endcase
        noise_sent++;
      end else begin
        reports_sent++;
      end
      push_frame(f);
    end

    // ---- wind down: collect everything, then idle before the verdict ----
    drain_results();
    repeat (10) @(posedge clk);

    $display(
      "Run covered %0d frames: %0d directed, %0d random well-formed, %0d malformed or noise.",
      directed_sent + reports_sent + noise_sent, directed_sent, reports_sent, noise_sent);
    $display("Both sides stalled at random, with one stall-free stretch and a full drain mid-run.");
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
